[src/tpz_pkg.sv]
// Shared types, constants and table functions of the torus point z-buffer shader.
`default_nettype none
package tpz_pkg;

	localparam int SCREEN_WIDTH_DEF  = 100;
	localparam int SCREEN_HEIGHT_DEF = 28;
	localparam int THETA_STEPS_DEF   = 100;
	localparam int PHI_STEPS_DEF     = 360;

	localparam int TURN    = 1800;
	localparam int QUARTER = 450;

	localparam int ANG_W = 11;
	localparam int A_W   = 17;
	localparam int T_W   = 16;
	localparam int P_W   = 33;
	localparam int S_W   = 34;
	localparam int NUM_W = 25;
	localparam int DEN_W = 20;

	localparam logic signed [A_W-1:0] R1_Q12  = 17'sd5120;
	localparam logic signed [A_W-1:0] R2_Q12  = 17'sd9421;
	localparam logic signed [17:0]    K2_Q12  = 18'sd24576;
	localparam logic signed [T_W-1:0] LIGHT_Y = -16'sd10960;
	localparam logic signed [T_W-1:0] LIGHT_Z = 16'sd12178;
	localparam logic [3:0]            BLANK_IDX = 4'd13;
	localparam logic [3:0]            RAMP_TOP  = 4'd12;
	localparam logic signed [15:0]    FAR_DEPTH = 16'sd32767;

	localparam logic CFG_ANGLE_A = 1'b0;
	localparam logic CFG_ANGLE_B = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PLOT  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PLOT,
		OP_READ,
		OP_READ_OFF,
		OP_NOP
	} job_op_t;

	typedef enum logic [3:0] {
		MOP_TX, MOP_TY, MOP_X1, MOP_Z1, MOP_Y2, MOP_Z2, MOP_P0, MOP_P1,
		MOP_NX1, MOP_NZ1, MOP_NY2, MOP_NZ2, MOP_NY, MOP_DOT
	} mac_op_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_TRIG, B_MAC, B_DEN, B_DIVX, B_WAITX, B_DIVY, B_WAITY,
		B_MAP, B_ADDR, B_RD, B_TEST, B_SHADE, B_RESULT
	} back_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] theta_index;
		logic [8:0] phi_index;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} item_t;

	typedef struct packed {
		logic [6:0] glyph;
		logic       depth_won;
		logic       off_screen;
	} result_t;

	typedef struct packed {
		job_op_t    op;
		logic [6:0] theta_index;
		logic [8:0] phi_index;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} job_t;

	// quarter-wave sine, Q14, for elaboration-time tables only
	function automatic logic [14:0] sin_quarter(input int v);
		longint unsigned x, x2, t3, t5, t7, t9;
		longint s;
		x  = longint'(v) * 64'd3748066;
		x2 = (x * x) >> 30;
		t3 = (x * x2) >> 30;
		t5 = (t3 * x2) >> 30;
		t7 = (t5 * x2) >> 30;
		t9 = (t7 * x2) >> 30;
		s  = longint'(x) - longint'(t3 / 6) + longint'(t5 / 120)
		   - longint'(t7 / 5040) + longint'(t9 / 362880);
		if (s < 0) s = 0;
		return 15'((s + 32768) >>> 16);
	endfunction

	function automatic logic [6:0] ramp_char(input logic [3:0] g);
		logic [6:0] c;
		case (g)
			4'd0:    c = 7'h2E;
			4'd1:    c = 7'h2C;
			4'd2:    c = 7'h2D;
			4'd3:    c = 7'h7E;
			4'd4:    c = 7'h3A;
			4'd5:    c = 7'h3B;
			4'd6:    c = 7'h3D;
			4'd7:    c = 7'h21;
			4'd8:    c = 7'h2A;
			4'd9:    c = 7'h23;
			4'd10:   c = 7'h24;
			4'd11:   c = 7'h40;
			4'd12:   c = 7'h38;
			default: c = 7'h20;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[src/tpz_fifo.sv]
// Small first-in first-out queue of packed words.
`default_nettype none
module tpz_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      dout
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == (PTR_W+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

[src/tpz_front.sv]
// Front end: decodes and classifies items into a short job queue.
`default_nettype none
module tpz_front import tpz_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	input  wire logic  job_pop,
	output logic       job_valid,
	output job_t       job
);
	job_t                cls;
	logic                jq_empty;
	logic [$bits(job_t)-1:0] jq_dout;

	always_comb begin
		cls.theta_index = item.theta_index;
		cls.phi_index   = item.phi_index;
		cls.read_col    = item.read_col;
		cls.read_row    = item.read_row;
		case (item.cmd)
			CMD_CLEAR: cls.op = OP_CLEAR;
			CMD_PLOT:  cls.op = OP_PLOT;
			CMD_READ: begin
				if (9'(item.read_col) < 9'(SCREEN_WIDTH) && 8'(item.read_row) < 8'(SCREEN_HEIGHT))
					cls.op = OP_READ;
				else
					cls.op = OP_READ_OFF;
			end
			default:   cls.op = OP_NOP;
		endcase
	end

	tpz_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (cls),
		.pop   (job_pop),
		.empty (jq_empty),
		.dout  (jq_dout)
	);

	assign job_valid = ~jq_empty;
	assign job       = job_t'(jq_dout);

endmodule
`default_nettype wire

[src/tpz_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module tpz_div import tpz_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   shifted, diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};
	assign done    = done_q;
	assign quot    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

[src/tpz_back.sv]
// Back end: trig lookups, rotation, projection, depth test, shading, pixel store, clears and reads.
`default_nettype none
module tpz_back import tpz_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int THETA_STEPS   = THETA_STEPS_DEF,
	parameter int PHI_STEPS     = PHI_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic       job_valid,
	input  wire job_t       job,
	output logic            job_pop,
	input  wire logic       res_full,
	output logic            res_push,
	output result_t         result,
	output logic            init_busy
);
	localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int IDX_W  = $clog2(PIXELS);
	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int Q_W    = NUM_W + 1;
	localparam int C_W    = NUM_W + 2;

	// constant tables
	logic [ANG_W-1:0] theta_tab [128];
	logic [ANG_W-1:0] phi_tab   [512];
	logic [14:0]      sin_tab   [512];

	for (genvar i = 0; i < 128; i++) begin : g_theta
		localparam int U = (i * TURN / THETA_STEPS) % TURN;
		assign theta_tab[i] = ANG_W'(U);
	end
	for (genvar i = 0; i < 512; i++) begin : g_phi
		localparam int U = (i * TURN / PHI_STEPS) % TURN;
		localparam logic [14:0] S = (i <= QUARTER) ? sin_quarter(i) : 15'd0;
		assign phi_tab[i] = ANG_W'(U);
		assign sin_tab[i] = S;
	end

	back_state_t state_q, state_d;

	logic [8:0]       fa_q, fb_q;
	logic [IDX_W-1:0] clr_q;
	logic             clr_reply_q;
	logic [2:0]       k_q;
	logic [1:0]       ph_q;
	mac_op_t          op_q;

	logic [ANG_W-1:0] th_q, phu_q, ua_q, ub_q;
	logic [8:0]       sidx_q;
	logic             sneg_q;
	logic [14:0]      sval_q;
	logic signed [T_W-1:0] trig_q [8];
	logic signed [A_W-1:0] tx_q, ty_q, x1_q, z1_q, y2_q, z2_q, p0_q, p1_q;
	logic signed [S_W-1:0] dot_q, acc_q;
	logic signed [P_W-1:0] prod_q;
	logic             is_read_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] idx_q;
	logic [19:0]      rd_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] dv_q;
	logic [17:0]      den_keep_q;
	logic             neg_q;
	logic signed [Q_W-1:0] xq_q, yq_q;
	result_t          res_q;
	logic [19:0]      mem [PIXELS];

	logic             mem_we;
	logic [IDX_W-1:0] wr_addr;
	logic [19:0]      wr_data;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_quot;

	// ---- combinational helpers
	logic [11:0] ang_base, ang_u, ua5;
	logic [8:0]  q_idx;
	logic        q_neg;
	logic signed [A_W-1:0] mac_a;
	logic signed [T_W-1:0] mac_c;
	logic signed [S_W-1:0] mac_sum, rnd_s;
	logic [S_W-1:0]        mag_u, rmag_u;
	logic signed [A_W-1:0] rnd;
	logic signed [17:0]    den_s;
	logic                  den_pos;
	logic [A_W-1:0]        mag0, mag1;
	logic signed [Q_W-1:0] q_signed;
	logic signed [C_W-1:0] col_s, row_s;
	logic                  map_ok, won, last_mac;
	logic [S_W-1:0]        dot_m;
	logic [S_W+3:0]        dot_12;
	logic [S_W-25:0]       k_raw;
	logic [3:0]            new_g;

	assign ua5 = 12'(fa_q) * 12'd5;

	always_comb begin
		case (k_q[2:1])
			2'd0:    ang_base = 12'(th_q);
			2'd1:    ang_base = 12'(phu_q);
			2'd2:    ang_base = 12'(ua_q);
			default: ang_base = 12'(ub_q);
		endcase
		ang_u = ang_base + (k_q[0] ? 12'd0 : 12'(QUARTER));
		if (ang_u >= 12'(TURN)) ang_u = ang_u - 12'(TURN);
		if (ang_u < 12'(QUARTER)) begin
			q_idx = 9'(ang_u);
			q_neg = 1'b0;
		end else if (ang_u < 12'(2*QUARTER)) begin
			q_idx = 9'(12'(2*QUARTER) - ang_u);
			q_neg = 1'b0;
		end else if (ang_u < 12'(3*QUARTER)) begin
			q_idx = 9'(ang_u - 12'(2*QUARTER));
			q_neg = 1'b1;
		end else begin
			q_idx = 9'(12'(TURN) - ang_u);
			q_neg = 1'b1;
		end
	end

	// trig_q: 0 ct, 1 st, 2 cos phi, 3 sin phi, 4 cos a, 5 sin a, 6 cos b, 7 sin b
	always_comb begin
		mac_a = '0;
		mac_c = '0;
		case (op_q)
			MOP_TX:  begin mac_a = ph_q[0] ? '0 : R1_Q12;      mac_c = trig_q[0]; end
			MOP_TY:  begin mac_a = ph_q[0] ? '0 : R1_Q12;      mac_c = trig_q[1]; end
			MOP_X1:  begin mac_a = ph_q[0] ? '0 : tx_q;        mac_c = trig_q[2]; end
			MOP_Z1:  begin mac_a = ph_q[0] ? '0 : tx_q;        mac_c = trig_q[3]; end
			MOP_Y2:  begin mac_a = ph_q[0] ? z1_q : ty_q;
				mac_c = ph_q[0] ? -trig_q[5] : trig_q[4]; end
			MOP_Z2:  begin mac_a = ph_q[0] ? z1_q : ty_q;
				mac_c = ph_q[0] ? trig_q[4] : trig_q[5]; end
			MOP_P0:  begin mac_a = ph_q[0] ? y2_q : x1_q;
				mac_c = ph_q[0] ? -trig_q[7] : trig_q[6]; end
			MOP_P1:  begin mac_a = ph_q[0] ? y2_q : x1_q;
				mac_c = ph_q[0] ? trig_q[6] : trig_q[7]; end
			MOP_NX1: begin mac_a = ph_q[0] ? '0 : A_W'(trig_q[0]); mac_c = trig_q[2]; end
			MOP_NZ1: begin mac_a = ph_q[0] ? '0 : A_W'(trig_q[0]); mac_c = trig_q[3]; end
			MOP_NY2: begin mac_a = ph_q[0] ? z1_q : A_W'(trig_q[1]);
				mac_c = ph_q[0] ? -trig_q[5] : trig_q[4]; end
			MOP_NZ2: begin mac_a = ph_q[0] ? z1_q : A_W'(trig_q[1]);
				mac_c = ph_q[0] ? trig_q[4] : trig_q[5]; end
			MOP_NY:  begin mac_a = ph_q[0] ? y2_q : x1_q;
				mac_c = ph_q[0] ? trig_q[6] : trig_q[7]; end
			MOP_DOT: begin mac_a = ph_q[0] ? ty_q : p1_q;
				mac_c = ph_q[0] ? LIGHT_Z : LIGHT_Y; end
			default: begin mac_a = '0; mac_c = '0; end
		endcase
	end

	always_comb begin
		mac_sum = acc_q + S_W'(prod_q);
		mag_u   = mac_sum[S_W-1] ? S_W'(-mac_sum) : S_W'(mac_sum);
		rmag_u  = (mag_u + S_W'(8192)) >> 14;
		rnd_s   = mac_sum[S_W-1] ? -$signed(rmag_u) : $signed(rmag_u);
		rnd     = A_W'(rnd_s);
	end

	assign last_mac = (ph_q == 2'd2) && (op_q == MOP_P1 || op_q == MOP_DOT);

	assign den_s   = 18'(z2_q) + K2_Q12;
	assign den_pos = !den_s[17] && den_s != '0;
	assign mag0    = p0_q[A_W-1] ? A_W'(-p0_q) : A_W'(p0_q);
	assign mag1    = p1_q[A_W-1] ? A_W'(-p1_q) : A_W'(p1_q);
	assign q_signed = neg_q ? -$signed(Q_W'(div_quot)) : $signed(Q_W'(div_quot));

	assign col_s  = C_W'(xq_q) + C_W'(SCREEN_WIDTH / 2);
	assign row_s  = C_W'(yq_q) + C_W'(SCREEN_HEIGHT / 2);
	assign map_ok = !col_s[C_W-1] && col_s < C_W'(SCREEN_WIDTH)
	             && !row_s[C_W-1] && row_s < C_W'(SCREEN_HEIGHT);
	assign won    = z2_q < A_W'($signed(rd_q[19:4]));

	always_comb begin
		dot_m  = S_W'(-dot_q);
		dot_12 = (S_W+4)'(dot_m) * (S_W+4)'(12);
		k_raw  = dot_12[S_W+3:28];
		if (dot_q > 0)
			new_g = rd_q[3:0];
		else if (k_raw > (S_W-24)'(RAMP_TOP))
			new_g = RAMP_TOP;
		else
			new_g = 4'(k_raw);
	end

	// ---- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR:  if (clr_q == IDX_W'(PIXELS-1)) state_d = clr_reply_q ? B_RESULT : B_IDLE;
			B_IDLE: begin
				if (job_valid) begin
					case (job.op)
						OP_CLEAR: state_d = B_CLEAR;
						OP_PLOT:  state_d = B_TRIG;
						OP_READ:  state_d = B_ADDR;
						default:  state_d = B_RESULT;
					endcase
				end
			end
			B_TRIG:   if (k_q == 3'd7 && ph_q == 2'd2) state_d = B_MAC;
			B_MAC:    if (last_mac) state_d = (op_q == MOP_DOT) ? B_SHADE : B_DEN;
			B_DEN:    state_d = den_pos ? B_DIVX : B_RESULT;
			B_DIVX:   state_d = B_WAITX;
			B_WAITX:  if (div_done) state_d = B_DIVY;
			B_DIVY:   state_d = B_WAITY;
			B_WAITY:  if (div_done) state_d = B_MAP;
			B_MAP:    state_d = map_ok ? B_ADDR : B_RESULT;
			B_ADDR:   state_d = B_RD;
			B_RD:     state_d = B_TEST;
			B_TEST:   state_d = (!is_read_q && won) ? B_MAC : B_RESULT;
			B_SHADE:  state_d = B_RESULT;
			B_RESULT: if (!res_full) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// ---- strobes
	always_comb begin
		job_pop   = (state_q == B_IDLE) && job_valid;
		div_start = (state_q == B_DIVX) || (state_q == B_DIVY);
		res_push  = (state_q == B_RESULT) && !res_full;
		mem_we    = (state_q == B_CLEAR) || (state_q == B_SHADE);
		wr_addr   = (state_q == B_CLEAR) ? clr_q : idx_q;
		wr_data   = (state_q == B_CLEAR) ? {FAR_DEPTH, BLANK_IDX} : {z2_q[15:0], new_g};
		init_busy = (state_q == B_CLEAR) && !clr_reply_q;
	end

	assign result = res_q;

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			fa_q        <= '0;
			fb_q        <= '0;
			k_q         <= '0;
			ph_q        <= '0;
			op_q        <= MOP_TX;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_ANGLE_A) fa_q <= cfg_data;
				else                          fb_q <= cfg_data;
			end
			case (state_q)
				B_CLEAR: clr_q <= clr_q + 1'b1;
				B_IDLE: begin
					clr_q       <= '0;
					clr_reply_q <= job.op == OP_CLEAR;
					k_q         <= '0;
					ph_q        <= '0;
					op_q        <= MOP_TX;
				end
				B_TRIG: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						k_q  <= k_q + 1'b1;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				B_MAC: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						op_q <= mac_op_t'(op_q + 1'b1);
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				res_q            <= '0;
				res_q.off_screen <= job.op == OP_READ_OFF;
				is_read_q        <= job.op == OP_READ;
				col_q            <= COL_W'(job.read_col);
				row_q            <= ROW_W'(job.read_row);
				th_q             <= theta_tab[job.theta_index];
				phu_q            <= phi_tab[job.phi_index];
				ua_q             <= ANG_W'((ua5 >= 12'(TURN)) ? ua5 - 12'(TURN) : ua5);
				ub_q             <= ANG_W'(((12'(fb_q) * 12'd5) >= 12'(TURN))
				                    ? (12'(fb_q) * 12'd5) - 12'(TURN) : 12'(fb_q) * 12'd5);
			end
			B_TRIG: begin
				case (ph_q)
					2'd0:    begin sidx_q <= q_idx; sneg_q <= q_neg; end
					2'd1:    sval_q <= sin_tab[sidx_q];
					default: trig_q[k_q] <= sneg_q ? -$signed(T_W'(sval_q)) : $signed(T_W'(sval_q));
				endcase
			end
			B_MAC: begin
				case (ph_q)
					2'd0: prod_q <= P_W'(mac_a) * P_W'(mac_c);
					2'd1: begin
						acc_q  <= S_W'(prod_q);
						prod_q <= P_W'(mac_a) * P_W'(mac_c);
					end
					default: begin
						case (op_q)
							MOP_TX:  tx_q  <= rnd + R2_Q12;
							MOP_TY:  ty_q  <= rnd;
							MOP_X1:  x1_q  <= rnd;
							MOP_Z1:  z1_q  <= rnd;
							MOP_Y2:  y2_q  <= rnd;
							MOP_Z2:  z2_q  <= rnd;
							MOP_P0:  p0_q  <= rnd;
							MOP_P1:  p1_q  <= rnd;
							MOP_NX1: x1_q  <= rnd;
							MOP_NZ1: z1_q  <= rnd;
							MOP_NY2: y2_q  <= rnd;
							MOP_NZ2: ty_q  <= rnd;
							MOP_NY:  p1_q  <= rnd;
							MOP_DOT: dot_q <= mac_sum;
							default: ;
						endcase
					end
				endcase
			end
			B_DEN: begin
				if (!den_pos) res_q.off_screen <= 1'b1;
				den_keep_q <= den_s;
				neg_q      <= p0_q[A_W-1];
				num_q      <= NUM_W'(mag0) * NUM_W'(378);
				dv_q       <= DEN_W'(den_s) * DEN_W'(10);
			end
			B_WAITX: begin
				if (div_done) begin
					xq_q  <= q_signed;
					neg_q <= p1_q[A_W-1];
					num_q <= NUM_W'(mag1) * NUM_W'(18);
					dv_q  <= DEN_W'(den_keep_q);
				end
			end
			B_WAITY: if (div_done) yq_q <= q_signed;
			B_MAP: begin
				if (!map_ok) res_q.off_screen <= 1'b1;
				col_q <= COL_W'(col_s);
				row_q <= ROW_W'(row_s);
			end
			B_ADDR: idx_q <= IDX_W'(32'(col_q) * SCREEN_HEIGHT + 32'(row_q));
			B_TEST: begin
				if (!is_read_q && won) res_q.depth_won <= 1'b1;
				else                   res_q.glyph     <= ramp_char(rd_q[3:0]);
			end
			B_SHADE: res_q.glyph <= ramp_char(new_g);
			default: ;
		endcase
	end

	// pixel store: depth in the upper bits, glyph index in the lower four
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_q <= mem[idx_q];
	end

	tpz_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (dv_q),
		.done  (div_done),
		.quot  (div_quot)
	);

endmodule
`default_nettype wire

[src/torus_point_zbuffer_shader_unit.sv]
// Top level of the torus point z-buffer shader.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  input    | push / full        | item   (cmd, theta, phi, read col/row)
//  result   | pop / empty        | result (glyph, depth_won, off_screen)
//  config   | cfg_we             | cfg_index, cfg_data (frame angles a, b)
//
// A plot's run time is set by the shared multiplier, used for each rotation row, and
// by the bit-serial divider, run once each for x and y; a depth win adds the shading
// pass. A clear writes each of the SCREEN_WIDTH*SCREEN_HEIGHT pixels in turn.
// After reset the same clearing pass runs and full stays high for its length.
// Two jobs queue ahead of the back end and two results queue behind it.
`default_nettype none
module torus_point_zbuffer_shader_unit import tpz_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int THETA_STEPS   = THETA_STEPS_DEF,
	parameter int PHI_STEPS     = PHI_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [8:0] cfg_data
);
	logic    jq_full, init_busy, job_valid, job_pop, res_full, res_push;
	job_t    job;
	result_t back_res;
	logic [$bits(result_t)-1:0] rq_dout;

	assign full = jq_full | init_busy;

	tpz_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push & ~init_busy),
		.full     (jq_full),
		.item     (item),
		.job_pop  (job_pop),
		.job_valid(job_valid),
		.job      (job)
	);

	tpz_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.THETA_STEPS  (THETA_STEPS),
		.PHI_STEPS    (PHI_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.result   (back_res),
		.init_busy(init_busy)
	);

	tpz_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (back_res),
		.pop   (pop),
		.empty (empty),
		.dout  (rq_dout)
	);

	assign result = result_t'(rq_dout);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("job taken from empty queue");
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> job_valid) else $error("accepted item lost");

endmodule
`default_nettype wire

[test/torus_point_zbuffer_shader_unit_tb.sv]
// Self-checking testbench for the torus point z-buffer shader: directed and random traffic against a predictor.
`timescale 1ns / 100ps
module torus_point_zbuffer_shader_unit_tb;
	import tpz_pkg::*;

	localparam int COLS = 100;
	localparam int ROWS = 28;
	localparam int PIX  = COLS * ROWS;
	localparam string GLYPH_RAMP = ".,-~:;=!*#$@8";
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk, arst_n, push, full, empty, pop, cfg_we, cfg_index;
	logic [8:0] cfg_data;
	item_t item;
	result_t result;

	torus_point_zbuffer_shader_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	item_t pending_items[$];
	result_t expected_results[$];
	shortint depth_map[PIX];
	logic [3:0] shade_map[PIX];
	logic [8:0] angle_a, angle_b;
	int errors, last_col, last_row;
	int send_gap, recv_gap, send_max, recv_max;
	bit item_taken, result_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int quarter_sine(int v);
		longint unsigned x, x2, t3, t5, t7, t9;
		longint s;
		x  = longint'(v) * 64'd3748066;
		x2 = (x * x) >> 30;
		t3 = (x * x2) >> 30;
		t5 = (t3 * x2) >> 30;
		t7 = (t5 * x2) >> 30;
		t9 = (t7 * x2) >> 30;
		s = longint'(x) - longint'(t3 / 6) + longint'(t5 / 120)
			- longint'(t7 / 5040) + longint'(t9 / 362880);
		if (s < 0)
			s = 0;
		return int'((s + 32768) >>> 16);
	endfunction

	function automatic int sin_q14(int u);
		u = u % TURN;
		if (u < QUARTER)
			return quarter_sine(u);
		if (u < 2 * QUARTER)
			return quarter_sine(2 * QUARTER - u);
		if (u < 3 * QUARTER)
			return -quarter_sine(u - 2 * QUARTER);
		return -quarter_sine(TURN - u);
	endfunction

	function automatic int cos_q14(int u);
		return sin_q14((u % TURN) + QUARTER);
	endfunction

	function automatic int mac_round(int a, int c, int b, int e);
		longint p;
		p = longint'(a) * c + longint'(b) * e;
		if (p >= 0)
			return int'((p + 8192) >>> 14);
		return -int'(((-p) + 8192) >>> 14);
	endfunction

	task automatic spin(input int x, input int y, input int cs[6], output int v[3]);
		int x1, z1, y2;
		x1 = mac_round(x, cs[0], 0, 0);
		z1 = mac_round(x, cs[1], 0, 0);
		y2 = mac_round(y, cs[2], z1, -cs[3]);
		v[2] = mac_round(y, cs[3], z1, cs[2]);
		v[0] = mac_round(x1, cs[4], y2, -cs[5]);
		v[1] = mac_round(x1, cs[5], y2, cs[4]);
	endtask

	function automatic logic [6:0] shade_char(logic [3:0] g);
		if (g > 4'd12)
			return 7'h20;
		return 7'(GLYPH_RAMP[g]);
	endfunction

	task automatic shade_point(input item_t it, output result_t r);
		int th, ph, ct, st, idx, cs[6], p[3], n[3];
		longint den, xp, yp, col, row, d, k;
		r = '0;
		case (it.cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < PIX; i++) begin
					depth_map[i] = 16'sd32767;
					shade_map[i] = BLANK_IDX;
				end
			end
			CMD_PLOT: begin
				th = int'(it.theta_index) * TURN / 100;
				ph = int'(it.phi_index) * TURN / 360;
				ct = cos_q14(th);
				st = sin_q14(th);
				cs[0] = cos_q14(ph);
				cs[1] = sin_q14(ph);
				cs[2] = cos_q14(int'(angle_a) * 5);
				cs[3] = sin_q14(int'(angle_a) * 5);
				cs[4] = cos_q14(int'(angle_b) * 5);
				cs[5] = sin_q14(int'(angle_b) * 5);
				spin(9421 + mac_round(5120, ct, 0, 0), mac_round(5120, st, 0, 0), cs, p);
				den = longint'(p[2]) + 24576;
				if (den <= 0) begin
					r.off_screen = 1'b1;
				end else begin
					xp = (longint'(p[0]) * 378) / (den * 10);
					yp = (longint'(p[1]) * 18) / den;
					col = xp + COLS / 2;
					row = yp + ROWS / 2;
					if (col < 0 || col >= COLS || row < 0 || row >= ROWS) begin
						r.off_screen = 1'b1;
					end else begin
						idx = int'(col) * ROWS + int'(row);
						last_col = int'(col);
						last_row = int'(row);
						if (p[2] < int'(depth_map[idx])) begin
							r.depth_won = 1'b1;
							depth_map[idx] = shortint'(p[2]);
							spin(ct, st, cs, n);
							d = longint'(n[1]) * -10960 + longint'(n[2]) * 12178;
							if (d <= 0) begin
								k = ((-d) * 12) >>> 28;
								if (k > 12)
									k = 12;
								shade_map[idx] = 4'(k);
							end
						end
						r.glyph = shade_char(shade_map[idx]);
					end
				end
			end
			CMD_READ: begin
				if (it.read_col >= COLS || it.read_row >= ROWS)
					r.off_screen = 1'b1;
				else
					r.glyph = shade_char(shade_map[int'(it.read_col) * ROWS + int'(it.read_row)]);
			end
			default: ;
		endcase
	endtask

	// accepted items and results
	always @(posedge clk) begin
		result_t r, want;
		if (push && !full) begin
			shade_point(item, r);
			expected_results.push_back(r);
			item_taken = 1'b1;
		end
		if (pop && !empty) begin
			result_taken = 1'b1;
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.glyph !== want.glyph) begin
					$error("glyph exp %h got %h", want.glyph, result.glyph);
					errors++;
				end
				if (result.depth_won !== want.depth_won) begin
					$error("depth_won exp %b got %b", want.depth_won, result.depth_won);
					errors++;
				end
				if (result.off_screen !== want.off_screen) begin
					$error("off_screen exp %b got %b", want.off_screen, result.off_screen);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!push || item_taken) begin
			item_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				push <= 1'b1;
				send_gap = $urandom_range(0, send_max);
			end else begin
				push <= 1'b0;
			end
		end
		if (!pop || result_taken) begin
			result_taken = 1'b0;
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				recv_gap = $urandom_range(0, recv_max);
			end
		end
	end

	task automatic add_item(input cmd_t c, input int th, input int ph, input int rc, input int rr);
		item_t it;
		it.cmd = c;
		it.theta_index = 7'(th);
		it.phi_index = 9'(ph);
		it.read_col = 7'(rc);
		it.read_row = 5'(rr);
		pending_items.push_back(it);
	endtask

	task automatic write_angles(input logic [8:0] a, input logic [8:0] b);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_ANGLE_A;
		cfg_data = a;
		@(negedge clk);
		cfg_index = CFG_ANGLE_B;
		cfg_data = b;
		@(negedge clk);
		cfg_we = 1'b0;
		angle_a = a;
		angle_b = b;
	endtask

	task automatic drain;
		wait (pending_items.size() == 0 && !push && expected_results.size() == 0);
		repeat (200) @(negedge clk);
	endtask

	task automatic random_items(input int n);
		item_t it;
		int sel;
		for (int i = 0; i < n; i++) begin
			it = item_t'({$urandom, $urandom});
			sel = $urandom_range(0, 99);
			if (sel < 68)
				it.cmd = CMD_PLOT;
			else if (sel < 96)
				it.cmd = CMD_READ;
			else if (sel < 98)
				it.cmd = CMD_UNUSED;
			else
				it.cmd = CMD_CLEAR;
			if ($urandom_range(0, 9) != 0) begin
				it.theta_index = 7'($urandom_range(0, 99));
				it.phi_index = 9'($urandom_range(0, 359));
				it.read_col = 7'($urandom_range(0, COLS - 1));
				it.read_row = 5'($urandom_range(0, ROWS - 1));
			end
			if (it.cmd == CMD_READ && $urandom_range(0, 1) == 1) begin
				it.read_col = 7'(last_col);
				it.read_row = 5'(last_row);
			end
			pending_items.push_back(it);
		end
	endtask

	initial begin
		logic [8:0] pa[8] = '{9'd0, 9'd360, 9'd511, 9'd90, 9'd45, 9'd180, 9'd270, 9'd0};
		logic [8:0] pb[8] = '{9'd0, 9'd360, 9'd511, 9'd45, 9'd300, 9'd0, 9'd135, 9'd0};
		errors = 0;
		last_col = 0;
		last_row = 0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ANGLE_A;
		cfg_data = '0;
		send_gap = 0;
		recv_gap = 0;
		send_max = 19;
		recv_max = 19;
		angle_a = '0;
		angle_b = '0;
		for (int i = 0; i < PIX; i++) begin
			depth_map[i] = 16'sd32767;
			shade_map[i] = BLANK_IDX;
		end
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(CMD_READ, 0, 0, 0, 0);
		add_item(CMD_READ, 0, 0, 99, 27);
		add_item(CMD_READ, 0, 0, 100, 0);
		add_item(CMD_READ, 0, 0, 0, 28);
		add_item(CMD_READ, 127, 511, 127, 31);
		add_item(CMD_PLOT, 0, 0, 0, 0);
		add_item(CMD_PLOT, 0, 0, 0, 0);
		add_item(CMD_PLOT, 99, 359, 0, 0);
		add_item(CMD_PLOT, 50, 180, 0, 0);
		add_item(CMD_PLOT, 25, 90, 0, 0);
		add_item(CMD_PLOT, 75, 270, 0, 0);
		add_item(CMD_PLOT, 127, 511, 127, 31);
		add_item(CMD_PLOT, 100, 360, 0, 0);
		pending_items.push_back(item_t'({CMD_UNUSED, 7'd127, 9'd511, 7'd127, 5'd31}));
		add_item(CMD_READ, 0, 0, 50, 14);
		add_item(CMD_CLEAR, 127, 511, 127, 31);
		add_item(CMD_READ, 0, 0, 50, 14);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 4)
				write_angles(9'($urandom_range(0, 360)), 9'($urandom_range(0, 360)));
			else
				write_angles(pa[ph], pb[ph]);
			send_max = (ph % 3 == 1) ? 0 : 19;
			recv_max = (ph % 3 == 2) ? 0 : 19;
			random_items(80);
			drain();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#30ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
